@@ design/sfwt_pkg.sv @@
package sfwt_pkg;

  typedef struct packed {
    logic [63:0] flow_key;
    logic [31:0] hash_first;
    logic [31:0] hash_second;
    logic [63:0] now_ms;
    logic [15:0] depth_first;
    logic [15:0] depth_second;
  } sfwt_in_t;

  typedef struct packed {
    logic [3:0] worker;
    logic       found;
    logic       reassigned;
    logic       table_full;
  } sfwt_out_t;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StPick,
    StRead,
    StCheck,
    StDone
  } sfwt_state_e;

  typedef enum logic [0:0] {
    RegWorkerCount = 1'b0,
    RegIdleTimeout = 1'b1
  } sfwt_reg_e;

  localparam logic [4:0]  WorkerCountReset = 5'd1;
  localparam logic [31:0] IdleTimeoutReset = 32'd120000;

endpackage

@@ design/sfwt_pick.sv @@
module sfwt_pick import sfwt_pkg::*; #(
  parameter int MaxWorkers = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [4:0]  count_i,
  input  logic [31:0] hash_a_i,
  input  logic [31:0] hash_b_i,
  input  logic [15:0] depth_a_i,
  input  logic [15:0] depth_b_i,
  output logic        done_o,
  output logic [3:0]  worker_o
);

  // Both remainders are formed bit-serially, one quotient bit per cycle for both hashes.
  localparam logic [4:0] MaxCount = (MaxWorkers > 16) ? 5'd16 : 5'(MaxWorkers);

  logic [4:0]  n_q, n_d;
  logic [31:0] qa_q, qa_d, qb_q, qb_d;
  logic [4:0]  ra_q, ra_d, rb_q, rb_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [3:0]  worker_q, worker_d;
  logic [5:0]  ta, tb;
  logic [4:0]  ea, eb;

  always_comb begin
    n_d = n_q; qa_d = qa_q; qb_d = qb_q; ra_d = ra_q; rb_d = rb_q;
    cnt_d = cnt_q; run_d = run_q; done_d = 1'b0; worker_d = worker_q;
    ta = {ra_q, qa_q[31]};
    tb = {rb_q, qb_q[31]};
    ea = (ta >= {1'b0, n_q}) ? 5'(ta - {1'b0, n_q}) : ta[4:0];
    eb = (tb >= {1'b0, n_q}) ? 5'(tb - {1'b0, n_q}) : tb[4:0];
    if (start_i) begin
      n_d = (count_i == 5'd0) ? 5'd1 : ((count_i > MaxCount) ? MaxCount : count_i);
      qa_d = hash_a_i; qb_d = hash_b_i; ra_d = '0; rb_d = '0;
      cnt_d = '0; run_d = 1'b1;
    end else if (run_q) begin
      if (cnt_q == 6'd32) begin
        run_d = 1'b0;
        done_d = 1'b1;
        if (n_q == 5'd1) worker_d = '0;
        else if (ra_q == rb_q) worker_d = ra_q[3:0];
        else worker_d = (depth_a_i <= depth_b_i) ? ra_q[3:0] : rb_q[3:0];
      end else begin
        ra_d = ea; rb_d = eb;
        qa_d = {qa_q[30:0], 1'b0}; qb_d = {qb_q[30:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; qa_q <= qa_d; qb_q <= qb_d; ra_q <= ra_d; rb_q <= rb_d;
    cnt_q <= cnt_d; worker_q <= worker_d;
  end

  assign done_o = done_q;
  assign worker_o = worker_q;

endmodule

@@ design/sticky_flow_worker_table.sv @@
// Channel   | Ports                          | Transfer
// ----------+--------------------------------+-------------------------------
// input     | start_i, busy_o, in_i          | start_i high while busy_o low
// result    | out_valid_o, out_o             | one cycle strobe, no stall
// config    | psel_i..pwdata_i, prdata_o     | APB write, pready_o always high
// After reset a clearing pass writes all TableSlots entries, one per cycle, while
// busy_o is high. The worker pick runs beside the probes; each probed slot passes
// through StRead (memory read), then StCheck (compare and write). busy_o stays high
// until both the probes and the pick are done, and the result strobe comes in the
// first cycle with busy_o low. The receiver cannot stall; memories are single-port
// with a registered read; items are handled one at a time.
module sticky_flow_worker_table import sfwt_pkg::*; #(
  parameter int TableSlots = 1024,
  parameter int MaxWorkers = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  sfwt_in_t    in_i,
  output logic        out_valid_o,
  output sfwt_out_t   out_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int IdxW = $clog2(TableSlots);

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [3:0]  worker;
    logic [63:0] seen;
  } slot_t;

  slot_t mem_q [TableSlots];
  slot_t rd_q;

  sfwt_state_e state_q, state_d;
  sfwt_in_t    item_q;
  logic [4:0]  count_q;
  logic [31:0] timeout_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW:0]   probes_q, probes_d;
  logic        pick_start, pick_done, picked_q, picked_d;
  logic [3:0]  pick_worker;
  logic        wr_en;
  slot_t       wr_data;
  sfwt_out_t   res_q, res_d;
  logic        out_valid_q, out_valid_d;
  logic        cfg_wr;
  logic [63:0] age;

  sfwt_pick #(.MaxWorkers(MaxWorkers)) u_pick (
    .clk_i, .rst_ni,
    .start_i(pick_start),
    .count_i(count_q),
    .hash_a_i(item_q.hash_first),
    .hash_b_i(item_q.hash_second),
    .depth_a_i(item_q.depth_first),
    .depth_b_i(item_q.depth_second),
    .done_o(pick_done),
    .worker_o(pick_worker)
  );

  assign cfg_wr = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  always_comb begin
    case (paddr_i[2])
      RegWorkerCount: prdata_o = {27'd0, count_q};
      RegIdleTimeout: prdata_o = timeout_q;
      default:        prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= WorkerCountReset;
      timeout_q <= IdleTimeoutReset;
    end else if (cfg_wr && paddr_i[1:0] == 2'b00) begin
      if (paddr_i[2] == RegWorkerCount) count_q <= pwdata_i[4:0];
      else timeout_q <= pwdata_i;
    end
  end

  assign age = item_q.now_ms - rd_q.seen;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (idx_q == IdxW'(TableSlots - 1)) state_d = StIdle;
      StIdle:  if (start_i) state_d = StPick;
      StPick:  state_d = StRead;
      StRead:  state_d = StCheck;
      StCheck: begin
        if (!rd_q.valid || rd_q.key == item_q.flow_key ||
            probes_q == (IdxW+1)'(TableSlots - 1)) begin
          state_d = picked_q ? StIdle : StDone;
        end else begin
          state_d = StRead;
        end
      end
      StDone:  if (picked_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    probes_d = probes_q;
    pick_start = 1'b0;
    picked_d = picked_q || pick_done;
    wr_en = 1'b0;
    wr_data = rd_q;
    res_d = res_q;
    out_valid_d = 1'b0;
    case (state_q)
      StClear: begin
        wr_en = 1'b1;
        wr_data = '0;
        idx_d = idx_q + 1'b1;
      end
      StIdle: begin
        idx_d = in_i.flow_key[IdxW-1:0];
        probes_d = '0;
        picked_d = 1'b0;
      end
      StPick: pick_start = 1'b1;
      StCheck: begin
        // A hit, a free slot or a full table keeps the result pending until the pick is known.
        res_d = '0;
        if (!rd_q.valid) begin
          res_d.found = 1'b0;
        end else if (rd_q.key == item_q.flow_key) begin
          res_d.found = 1'b1;
          res_d.worker = rd_q.worker;
          res_d.reassigned = (item_q.now_ms > rd_q.seen) && (age > {32'd0, timeout_q});
          wr_en = 1'b1;
          wr_data.seen = item_q.now_ms;
        end else if (probes_q == (IdxW+1)'(TableSlots - 1)) begin
          res_d.table_full = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
          probes_d = probes_q + 1'b1;
        end
        if (state_d != StRead && picked_q) begin
          out_valid_d = 1'b1;
          if (!rd_q.valid) begin
            res_d.worker = pick_worker;
            wr_en = 1'b1;
            wr_data = '{valid: 1'b1, key: item_q.flow_key, worker: pick_worker,
                        seen: item_q.now_ms};
          end else if (res_d.reassigned) begin
            res_d.worker = pick_worker;
            wr_data.worker = pick_worker;
          end else if (res_d.table_full) begin
            res_d.worker = pick_worker;
          end
        end
      end
      StDone: begin
        if (picked_q) begin
          out_valid_d = 1'b1;
          if (!res_q.found && !res_q.table_full) begin
            res_d.worker = pick_worker;
            wr_en = 1'b1;
            wr_data = '{valid: 1'b1, key: item_q.flow_key, worker: pick_worker,
                        seen: item_q.now_ms};
          end else if (res_q.reassigned) begin
            res_d.worker = pick_worker;
            wr_en = 1'b1;
            wr_data = '{valid: 1'b1, key: item_q.flow_key, worker: pick_worker,
                        seen: item_q.now_ms};
          end else if (res_q.table_full) begin
            res_d.worker = pick_worker;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      idx_q <= '0;
      out_valid_q <= 1'b0;
      picked_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
      picked_q <= picked_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probes_q <= probes_d;
    res_q <= res_d;
    if (state_q == StIdle && start_i) item_q <= in_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[idx_q] <= wr_data;
    rd_q <= mem_q[idx_q];
  end

  assign busy_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_o = res_q;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import sfwt_pkg::*;

  localparam int Slots = 1024;
  localparam int WatchdogLimit = 20000;
  localparam int TailCycles = 60;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  sfwt_in_t    pkt;
  logic        res_valid;
  sfwt_out_t   res;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sticky_flow_worker_table uut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .in_i(pkt),
    .out_valid_o(res_valid), .out_o(res), .psel_i(psel), .penable_i(penable),
    .pwrite_i(pwrite), .paddr_i(paddr), .pwdata_i(pwdata), .prdata_o(prdata),
    .pready_o(pready)
  );

  // Predictor state: a mirror of the flow table and the two registers.
  logic        tbl_valid [Slots];
  logic [63:0] tbl_key   [Slots];
  logic [3:0]  tbl_worker[Slots];
  logic [63:0] tbl_seen  [Slots];
  logic [4:0]  cfg_workers;
  logic [31:0] cfg_timeout;

  sfwt_in_t  pending_pkts[$];
  sfwt_out_t expected_assignments[$];
  int        errors;
  int        send_idle_pct;
  int        quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [3:0] pick_worker(sfwt_in_t p);
    logic [31:0] n, a, b;
    n = cfg_workers;
    if (n == 0) n = 1;
    if (n > 16) n = 16;
    if (n == 1) return 4'd0;
    a = p.hash_first % n;
    b = p.hash_second % n;
    if (a == b) return a[3:0];
    return (p.depth_first <= p.depth_second) ? a[3:0] : b[3:0];
  endfunction

  function automatic sfwt_out_t assign_flow(sfwt_in_t p);
    sfwt_out_t r;
    int idx;
    idx = int'(p.flow_key[9:0]);
    r = '0;
    for (int i = 0; i < Slots; i++) begin
      if (!tbl_valid[idx]) begin
        r.worker = pick_worker(p);
        tbl_valid[idx] = 1'b1;
        tbl_key[idx] = p.flow_key;
        tbl_worker[idx] = r.worker;
        tbl_seen[idx] = p.now_ms;
        return r;
      end
      if (tbl_key[idx] == p.flow_key) begin
        if (p.now_ms > tbl_seen[idx] && (p.now_ms - tbl_seen[idx]) > {32'd0, cfg_timeout}) begin
          tbl_worker[idx] = pick_worker(p);
          r.reassigned = 1'b1;
        end
        tbl_seen[idx] = p.now_ms;
        r.worker = tbl_worker[idx];
        r.found = 1'b1;
        return r;
      end
      idx = (idx + 1) % Slots;
    end
    r.worker = pick_worker(p);
    r.table_full = 1'b1;
    return r;
  endfunction

  // Driver: one transfer per accepted start, gaps at the current idle rate.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      start <= 1'b0;
      pkt <= '0;
    end else begin
      if (start && !busy) begin
        expected_assignments.push_back(assign_flow(pkt));
      end
      if ((!start || !busy) && !(start && busy)) begin
        if (pending_pkts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pkt <= pending_pkts.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || res_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WatchdogLimit) begin
        $display("testbench: errors");
        $finish;
      end
      if (res_valid) begin
        if (expected_assignments.size() == 0) begin
          $error("result with no pending flow lookup");
          errors++;
        end else begin
          sfwt_out_t e;
          e = expected_assignments.pop_front();
          if (res.worker !== e.worker) begin
            $error("worker: expected %0d, got %0d", e.worker, res.worker);
            errors++;
          end
          if (res.found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, res.found);
            errors++;
          end
          if (res.reassigned !== e.reassigned) begin
            $error("reassigned: expected %0d, got %0d", e.reassigned, res.reassigned);
            errors++;
          end
          if (res.table_full !== e.table_full) begin
            $error("table_full: expected %0d, got %0d", e.table_full, res.table_full);
            errors++;
          end
        end
      end
    end
  end

  task automatic reg_write(sfwt_reg_e r, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (r == RegWorkerCount) cfg_workers = v[4:0];
    else cfg_timeout = v;
  endtask

  task automatic drain();
    while (pending_pkts.size() > 0 || start || expected_assignments.size() > 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  function automatic sfwt_in_t rand_pkt(logic [63:0] key, logic [63:0] now);
    sfwt_in_t p;
    p.flow_key = key;
    p.hash_first = $urandom;
    p.hash_second = $urandom;
    p.now_ms = now;
    p.depth_first = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(8));
    p.depth_second = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(8));
    return p;
  endfunction

  // One random phase: a pool of recurring flows with small time steps,
  // some large jumps, and occasional fresh keys.
  task automatic random_phase(int count, int idle);
    logic [63:0] pool[16];
    logic [63:0] clock_ms;
    sfwt_in_t p;
    send_idle_pct = idle;
    clock_ms = {$urandom, $urandom} >> $urandom_range(63);
    for (int i = 0; i < 16; i++) begin
      pool[i] = {$urandom, $urandom};
      if (i >= 8) pool[i][9:0] = pool[0][9:0] + 10'(i % 3);
    end
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: clock_ms = clock_ms + {$urandom, $urandom};
        1: clock_ms = clock_ms - $urandom_range(50);
        2, 3: clock_ms = clock_ms + $urandom;
        default: clock_ms = clock_ms + $urandom_range(200);
      endcase
      p = rand_pkt($urandom_range(4) == 0 ? {$urandom, $urandom}
                                          : pool[$urandom_range(15)], clock_ms);
      pending_pkts.push_back(p);
    end
    drain();
  endtask

  initial begin
    sfwt_in_t p;
    int fill;
    errors = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_workers = WorkerCountReset;
    cfg_timeout = IdleTimeoutReset;
    for (int i = 0; i < Slots; i++) tbl_valid[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, then extremes of every field.
    p = rand_pkt(64'd5, 64'd0);
    pending_pkts.push_back(p);
    p.now_ms = 64'd120000;
    pending_pkts.push_back(p);
    p.now_ms = 64'd240001;
    pending_pkts.push_back(p);
    drain();
    reg_write(RegWorkerCount, 32'd16);
    reg_write(RegIdleTimeout, 32'd0);
    p = '{flow_key: '1, hash_first: '1, hash_second: '0, now_ms: '1,
          depth_first: '1, depth_second: '0};
    pending_pkts.push_back(p);
    p.now_ms = '0;
    pending_pkts.push_back(p);
    p.now_ms = 64'd1;
    pending_pkts.push_back(p);
    p.now_ms = 64'd2;
    pending_pkts.push_back(p);
    p = '{flow_key: 64'h0000_0000_0000_0005 | (64'd1 << 40), hash_first: 32'd3,
          hash_second: 32'd7, now_ms: 64'd9, depth_first: 16'd4, depth_second: 16'd4};
    pending_pkts.push_back(p);
    p.hash_second = 32'd19;
    p.flow_key = p.flow_key + (64'd1 << 20);
    pending_pkts.push_back(p);
    p.flow_key = 64'hAAAA_5555_AAAA_5555;
    p.depth_first = 16'd5;
    pending_pkts.push_back(p);
    drain();
    reg_write(RegWorkerCount, 32'd0);
    reg_write(RegIdleTimeout, 32'hFFFF_FFFF);
    pending_pkts.push_back(rand_pkt(64'h5555_AAAA_5555_AAAA, 64'd0));
    pending_pkts.push_back(rand_pkt(64'h5555_AAAA_5555_AAAA, 64'hFFFF_FFFF));
    pending_pkts.push_back(rand_pkt(64'h5555_AAAA_5555_AAAA, 64'h1_FFFF_FFFF));
    pending_pkts.push_back(rand_pkt(64'h5555_AAAA_5555_AAAA, 64'h3_FFFF_FFFF));
    drain();
    reg_write(RegWorkerCount, 32'd31);
    pending_pkts.push_back(rand_pkt(64'd77, 64'd5));
    drain();

    reg_write(RegWorkerCount, 32'd5);
    reg_write(RegIdleTimeout, 32'd100);
    random_phase(250, 20);
    reg_write(RegWorkerCount, 32'd2);
    reg_write(RegIdleTimeout, 32'd1000);
    random_phase(250, 49);
    reg_write(RegWorkerCount, 32'd16);
    reg_write(RegIdleTimeout, 32'd50);
    random_phase(200, 0);

    // Fill the free slots with distinct keys until it reports full, then revisit.
    reg_write(RegWorkerCount, 32'd3);
    send_idle_pct = 0;
    fill = Slots + 8;
    for (int i = 0; i < Slots; i++)
      if (tbl_valid[i]) fill--;
    for (int i = 0; i < fill; i++)
      pending_pkts.push_back(rand_pkt({$urandom, $urandom}, 64'(i)));
    drain();
    for (int i = 0; i < 12; i++)
      pending_pkts.push_back(rand_pkt(64'd5, 64'd400000 + 64'(i)));
    drain();

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
